FILE: rtl/pwu_pkg.sv
// Package for the particle weight update core: field widths, register codes,
// the configuration struct and small arithmetic helpers (absolute difference, saturating adds).
// Has no dependencies.
package pwu_pkg;

    localparam int unsigned DefMaxLandmarks = 64;
    localparam int unsigned DefSineDepth    = 1024;

    localparam int IdxW   = 6;
    localparam int CoordW = 32;
    localparam int HeadW  = 16;
    localparam int FacW   = 24;
    localparam int WideW  = 40;
    localparam int CntW   = 8;
    localparam int LcntW  = 7;
    localparam int SqW    = 64;
    localparam int AddrW  = 5;
    localparam int DataW  = 64;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_OBS  = 1'b1;

    typedef enum logic [1:0] {
        REG_INV_X  = 2'd0,
        REG_INV_Y  = 2'd1,
        REG_RANGE  = 2'd2,
        REG_LCOUNT = 2'd3
    } t_reg_idx;

    localparam logic [FacW-1:0]  FacReset    = 24'd65536;
    localparam logic [WideW-1:0] RangeReset  = 40'd2621440000;
    localparam logic [LcntW-1:0] LcountReset = 7'd64;
    localparam logic [SqW-1:0]   FarScore    = 64'd1048576000000000000;
    localparam logic [WideW-1:0] Max40       = {WideW{1'b1}};

    typedef struct packed {
        logic [FacW-1:0]  inv_two_var_x;
        logic [FacW-1:0]  inv_two_var_y;
        logic [WideW-1:0] range_squared;
        logic [LcntW-1:0] landmark_count;
    } t_cfg;

    function automatic logic [CoordW-1:0] abs_diff(input logic signed [CoordW-1:0] a,
                                                   input logic signed [CoordW-1:0] b);
        logic signed [CoordW:0] d;
        d = 33'(a) - 33'(b);
        abs_diff = d[CoordW] ? CoordW'(-d) : d[CoordW-1:0];
    endfunction

    function automatic logic [SqW-1:0] sat_add64(input logic [SqW-1:0] a,
                                                 input logic [SqW-1:0] b);
        logic [SqW:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add64 = s[SqW] ? {SqW{1'b1}} : s[SqW-1:0];
    endfunction

    function automatic logic [WideW-1:0] sat_add40(input logic [WideW-1:0] a,
                                                   input logic [WideW-1:0] b);
        logic [WideW:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add40 = s[WideW] ? Max40 : s[WideW-1:0];
    endfunction

endpackage

FILE: rtl/pwu_if.sv
// Channel interfaces of the particle weight update core: the input item
// channel and the result channel. Depends on pwu_pkg.
interface pwu_in_if;
    import pwu_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [IdxW-1:0]          landmark_index;
    logic signed [CoordW-1:0] landmark_x;
    logic signed [CoordW-1:0] landmark_y;
    logic signed [CoordW-1:0] particle_x;
    logic signed [CoordW-1:0] particle_y;
    logic [HeadW-1:0]         particle_heading;
    logic signed [CoordW-1:0] obs_x;
    logic signed [CoordW-1:0] obs_y;
    logic                     last_obs;

    modport source (output valid, req_type, landmark_index, landmark_x, landmark_y,
                    particle_x, particle_y, particle_heading, obs_x, obs_y, last_obs,
                    input ready);
    modport sink (input valid, req_type, landmark_index, landmark_x, landmark_y,
                  particle_x, particle_y, particle_heading, obs_x, obs_y, last_obs,
                  output ready);
endinterface

interface pwu_out_if;
    import pwu_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [IdxW-1:0]          assoc_index;
    logic signed [CoordW-1:0] map_x;
    logic signed [CoordW-1:0] map_y;
    logic [WideW-1:0]         gauss_exp;
    logic [WideW-1:0]         exp_sum;
    logic [CntW-1:0]          obs_count;
    logic                     is_last;

    modport source (output valid, assoc_index, map_x, map_y, gauss_exp, exp_sum,
                    obs_count, is_last, input ready);
    modport sink (input valid, assoc_index, map_x, map_y, gauss_exp, exp_sum,
                  obs_count, is_last, output ready);
endinterface

FILE: rtl/pwu_apb_regs.sv
// APB configuration registers of the particle weight update core.
// Depends on pwu_pkg.
module pwu_apb_regs (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [pwu_pkg::AddrW-1:0] paddr,
    input  logic [pwu_pkg::DataW-1:0] pwdata,
    output logic [pwu_pkg::DataW-1:0] prdata,
    output logic                   pready,
    output pwu_pkg::t_cfg          o_cfg
);
    import pwu_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;

    assign idx    = t_reg_idx'(paddr[4:3]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_two_var_x  <= FacReset;
            r_cfg.inv_two_var_y  <= FacReset;
            r_cfg.range_squared  <= RangeReset;
            r_cfg.landmark_count <= LcountReset;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_INV_X:  r_cfg.inv_two_var_x  <= pwdata[FacW-1:0];
                REG_INV_Y:  r_cfg.inv_two_var_y  <= pwdata[FacW-1:0];
                REG_RANGE:  r_cfg.range_squared  <= pwdata[WideW-1:0];
                REG_LCOUNT: r_cfg.landmark_count <= pwdata[LcntW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_INV_X:  prdata = DataW'(r_cfg.inv_two_var_x);
            REG_INV_Y:  prdata = DataW'(r_cfg.inv_two_var_y);
            REG_RANGE:  prdata = DataW'(r_cfg.range_squared);
            REG_LCOUNT: prdata = DataW'(r_cfg.landmark_count);
            default:    prdata = '0;
        endcase
    end
endmodule

FILE: rtl/pwu_lmk_mem.sv
// Landmark table: one write port and one registered read port holding the
// x and y map coordinates of each landmark. Depends on pwu_pkg.
module pwu_lmk_mem #(
    parameter int unsigned MAX_LANDMARKS = pwu_pkg::DefMaxLandmarks,
    parameter int unsigned AW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [AW-1:0]                        i_waddr,
    input  logic signed [pwu_pkg::CoordW-1:0]    i_wx,
    input  logic signed [pwu_pkg::CoordW-1:0]    i_wy,
    input  logic [AW-1:0]                        i_raddr,
    output logic signed [pwu_pkg::CoordW-1:0]    o_rx,
    output logic signed [pwu_pkg::CoordW-1:0]    o_ry
);
    import pwu_pkg::*;

    logic [2*CoordW-1:0] mem [MAX_LANDMARKS];
    logic [2*CoordW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wx, i_wy};
        end
        r_rd <= mem[i_raddr];
    end

    assign o_rx = r_rd[2*CoordW-1:CoordW];
    assign o_ry = r_rd[CoordW-1:0];
endmodule

FILE: rtl/pwu_sine_rom.sv
// Quarter-wave sine table in Q1.15 with two registered read ports; the
// entries are computed at elaboration. Depends on pwu_pkg.
module pwu_sine_rom #(
    parameter int unsigned SINE_TABLE_DEPTH = pwu_pkg::DefSineDepth,
    parameter int unsigned SAW = $clog2(SINE_TABLE_DEPTH)
) (
    input  logic           i_clk,
    input  logic [SAW-1:0] i_addr_a,
    input  logic [SAW-1:0] i_addr_b,
    output logic [15:0]    o_data_a,
    output logic [15:0]    o_data_b
);
    import pwu_pkg::*;

    typedef logic [15:0] t_rom [SINE_TABLE_DEPTH];

    localparam longint unsigned HalfPiQ30 = 64'd1686629713;

    function automatic logic [15:0] sine_entry(input longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          acc;
        longint          r;
        x   = (k * HalfPiQ30) / SINE_TABLE_DEPTH;
        x2  = (x * x) >> 30;
        acc = longint'(x);
        t   = ((x * x2) >> 30) / 6;
        acc = acc - longint'(t);
        t   = ((t * x2) >> 30) / 20;
        acc = acc + longint'(t);
        t   = ((t * x2) >> 30) / 42;
        acc = acc - longint'(t);
        t   = ((t * x2) >> 30) / 72;
        acc = acc + longint'(t);
        t   = ((t * x2) >> 30) / 110;
        acc = acc - longint'(t);
        if (acc < 0) begin
            acc = 0;
        end
        r = (acc + 16384) >>> 15;
        if (r > 32768) begin
            r = 32768;
        end
        sine_entry = r[15:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom tab;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            tab[k] = sine_entry(longint'(k));
        end
        build_rom = tab;
    endfunction

    localparam t_rom Rom = build_rom();

    always_ff @(posedge i_clk) begin
        o_data_a <= Rom[i_addr_a];
        o_data_b <= Rom[i_addr_b];
    end
endmodule

FILE: rtl/particle_weight_update_core.sv
// Particle weight update core: an observation runs from transfer in to result valid
// through a landmark scan over landmark_count entries (landmark_count clamped to 1 and
// to MAX_LANDMARKS) that reads one table entry per cycle from the landmark memory; the
// next item is taken in the cycle after the result is loaded, and a load does not leave
// the idle state. One observation is in work at a time, and the next item is taken while
// a result waits on the output.
// Depends on pwu_pkg, pwu_if, pwu_apb_regs, pwu_lmk_mem and pwu_sine_rom.
module particle_weight_update_core #(
    parameter int unsigned MAX_LANDMARKS    = pwu_pkg::DefMaxLandmarks,
    parameter int unsigned SINE_TABLE_DEPTH = pwu_pkg::DefSineDepth
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pwu_in_if.sink                     i_obs,
    pwu_out_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pwu_pkg::AddrW-1:0]  paddr,
    input  logic [pwu_pkg::DataW-1:0]  pwdata,
    output logic [pwu_pkg::DataW-1:0]  prdata,
    output logic                       pready
);
    import pwu_pkg::*;

    localparam int unsigned AW  = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int unsigned CW  = $clog2(MAX_LANDMARKS + 1);
    localparam int unsigned SAW = $clog2(SINE_TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_ROM, S_MUL, S_MAP, S_SCAN, S_SCALE, S_TERM, S_OUT
    } t_state;

    t_state r_state;
    t_cfg   cfg;

    pwu_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input side.
    logic in_xfer;
    logic lmk_we;
    assign i_obs.ready = (r_state == S_IDLE);
    assign in_xfer     = i_obs.valid && i_obs.ready;
    assign lmk_we      = in_xfer && (i_obs.req_type == REQ_LOAD) &&
                         (32'(i_obs.landmark_index) < 32'(MAX_LANDMARKS));

    logic signed [CoordW-1:0] r_px, r_py, r_ox, r_oy;
    logic [HeadW-1:0]         r_heading;
    logic                     r_last;

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_obs.req_type == REQ_OBS) begin
            r_px      <= i_obs.particle_x;
            r_py      <= i_obs.particle_y;
            r_ox      <= i_obs.obs_x;
            r_oy      <= i_obs.obs_y;
            r_heading <= i_obs.particle_heading;
            r_last    <= i_obs.last_obs;
        end
    end

    // Sine and cosine lookup.
    function automatic logic [14:0] quarter_u(input logic [HeadW-1:0] h);
        quarter_u = h[14] ? (15'd16384 - {1'b0, h[13:0]}) : {1'b0, h[13:0]};
    endfunction

    function automatic logic [SAW-1:0] quarter_addr(input logic [14:0] u);
        logic [45:0] p;
        p = 46'(u[13:0]) * 46'(SINE_TABLE_DEPTH);
        quarter_addr = p[14 +: SAW];
    endfunction

    logic [HeadW-1:0] h_cos;
    logic [14:0]      u_sin, u_cos;
    logic [15:0]      rom_s, rom_c;
    logic             r_full_s, r_full_c, r_neg_s, r_neg_c;

    assign h_cos = r_heading + 16'h4000;
    assign u_sin = quarter_u(r_heading);
    assign u_cos = quarter_u(h_cos);

    pwu_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAW              (SAW)
    ) u_rom (
        .i_clk    (i_clk),
        .i_addr_a (quarter_addr(u_sin)),
        .i_addr_b (quarter_addr(u_cos)),
        .o_data_a (rom_s),
        .o_data_b (rom_c)
    );

    always_ff @(posedge i_clk) begin
        r_full_s <= u_sin[14];
        r_full_c <= u_cos[14];
        r_neg_s  <= r_heading[15];
        r_neg_c  <= h_cos[15];
    end

    logic [16:0]        mag_s, mag_c;
    logic signed [16:0] sin_v, cos_v;
    assign mag_s = r_full_s ? 17'd32768 : {1'b0, rom_s};
    assign mag_c = r_full_c ? 17'd32768 : {1'b0, rom_c};
    assign sin_v = r_neg_s ? -$signed(mag_s) : $signed(mag_s);
    assign cos_v = r_neg_c ? -$signed(mag_c) : $signed(mag_c);

    // Rotation products and translation.
    logic signed [48:0] r_oxc, r_oys, r_oxs, r_oyc;
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_oxc <= r_ox * cos_v;
            r_oys <= r_oy * sin_v;
            r_oxs <= r_ox * sin_v;
            r_oyc <= r_oy * cos_v;
        end
    end

    function automatic logic signed [CoordW-1:0] sat32(input logic signed [50:0] v);
        if (v > 51'sd2147483647) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < -51'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[CoordW-1:0];
        end
    endfunction

    logic signed [49:0] vx, vy;
    logic signed [50:0] mx_w, my_w;
    assign vx   = 50'(r_oxc) - 50'(r_oys) + 50'sd16384;
    assign vy   = 50'(r_oxs) + 50'(r_oyc) + 50'sd16384;
    assign mx_w = 51'(r_px) + 51'(vx >>> 15);
    assign my_w = 51'(r_py) + 51'(vy >>> 15);

    logic signed [CoordW-1:0] r_mx, r_my;
    logic [CW-1:0]            r_n, r_issue;

    always_ff @(posedge i_clk) begin
        if (r_state == S_MAP) begin
            r_mx <= sat32(mx_w);
            r_my <= sat32(my_w);
        end
    end

    // Landmark scan pipeline.
    logic signed [CoordW-1:0] lx, ly;
    logic                     rd_en;
    assign rd_en = (r_state == S_SCAN) && (r_issue < r_n);

    pwu_lmk_mem #(
        .MAX_LANDMARKS (MAX_LANDMARKS),
        .AW            (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (lmk_we),
        .i_waddr (AW'(i_obs.landmark_index)),
        .i_wx    (i_obs.landmark_x),
        .i_wy    (i_obs.landmark_y),
        .i_raddr (r_issue[AW-1:0]),
        .o_rx    (lx),
        .o_ry    (ly)
    );

    logic [LcntW-1:0] lc;
    logic [CW-1:0]    n_eff;
    assign lc    = cfg.landmark_count;
    assign n_eff = (lc == '0) ? CW'(1) :
                   ((32'(lc) > 32'(MAX_LANDMARKS)) ? CW'(MAX_LANDMARKS) : CW'(lc));

    logic              r_v0, r_v1, r_v2, r_v3, r_first;
    logic [AW-1:0]     r_i0, r_i1, r_i2, r_i3, r_best;
    logic [CoordW-1:0] r_apx, r_apy, r_amx, r_amy;
    logic [SqW-1:0]    r_spx, r_spy, r_smx, r_smy;
    logic [SqW-1:0]    r_score, r_sqx3, r_sqy3;
    logic [SqW-1:0]    r_best_score, r_bsqx, r_bsqy;
    logic [SqW-1:0]    dpart, dmap;

    assign dpart = sat_add64(r_spx, r_spy);
    assign dmap  = sat_add64(r_smx, r_smy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_first <= 1'b0;
            r_issue <= '0;
            r_n     <= '0;
        end else begin
            r_v0 <= rd_en;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_state == S_MAP) begin
                r_issue <= '0;
                r_n     <= n_eff;
                r_first <= 1'b1;
            end else if (rd_en) begin
                r_issue <= r_issue + CW'(1);
            end
            if (r_v3) begin
                r_first <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i0  <= r_issue[AW-1:0];
        r_i1  <= r_i0;
        r_apx <= abs_diff(r_px, lx);
        r_apy <= abs_diff(r_py, ly);
        r_amx <= abs_diff(r_mx, lx);
        r_amy <= abs_diff(r_my, ly);
        r_i2  <= r_i1;
        r_spx <= r_apx * r_apx;
        r_spy <= r_apy * r_apy;
        r_smx <= r_amx * r_amx;
        r_smy <= r_amy * r_amy;
        r_i3  <= r_i2;
        r_sqx3  <= r_smx;
        r_sqy3  <= r_smy;
        r_score <= (dpart <= SqW'(cfg.range_squared)) ? dmap : FarScore;
        if (r_v3 && (r_first || r_score < r_best_score)) begin
            r_best       <= r_i3;
            r_best_score <= r_score;
            r_bsqx       <= r_sqx3;
            r_bsqy       <= r_sqy3;
        end
    end

    // Gaussian exponent.
    logic [55:0] r_hx, r_lx, r_hy, r_ly;
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCALE) begin
            r_hx <= r_bsqx[63:32] * cfg.inv_two_var_x;
            r_lx <= r_bsqx[31:0]  * cfg.inv_two_var_x;
            r_hy <= r_bsqy[63:32] * cfg.inv_two_var_y;
            r_ly <= r_bsqy[31:0]  * cfg.inv_two_var_y;
        end
    end

    function automatic logic [WideW-1:0] scale_fin(input logic [55:0] hi,
                                                   input logic [55:0] lo);
        logic [56:0] rl;
        rl = 57'(lo) + 57'd524288;
        if (hi >= 56'd268435456) begin
            scale_fin = Max40;
        end else begin
            scale_fin = sat_add40({hi[27:0], 12'd0}, WideW'(rl[56:20]));
        end
    endfunction

    logic [WideW-1:0] r_tx, r_ty, term, new_sum;
    always_ff @(posedge i_clk) begin
        if (r_state == S_TERM) begin
            r_tx <= scale_fin(r_hx, r_lx);
            r_ty <= scale_fin(r_hy, r_ly);
        end
    end

    logic [WideW-1:0] r_run_sum;
    logic [CntW-1:0]  r_run_cnt, new_cnt;
    logic             out_load;

    assign term     = sat_add40(r_tx, r_ty);
    assign new_sum  = sat_add40(r_run_sum, term);
    assign new_cnt  = (r_run_cnt == 8'd255) ? r_run_cnt : r_run_cnt + 8'd1;
    assign out_load = (r_state == S_OUT) && (!o_res.valid || o_res.ready);

    // Control and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_res.valid <= 1'b0;
            r_run_sum   <= '0;
            r_run_cnt   <= '0;
        end else begin
            if (o_res.valid && o_res.ready && !out_load) begin
                o_res.valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_obs.req_type == REQ_OBS) begin
                        r_state <= S_ROM;
                    end
                end
                S_ROM:   r_state <= S_MUL;
                S_MUL:   r_state <= S_MAP;
                S_MAP:   r_state <= S_SCAN;
                S_SCAN: begin
                    if (r_issue == r_n && !r_v0 && !r_v1 && !r_v2 && !r_v3) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: r_state <= S_TERM;
                S_TERM:  r_state <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        o_res.valid       <= 1'b1;
                        o_res.assoc_index <= IdxW'(r_best);
                        o_res.map_x       <= r_mx;
                        o_res.map_y       <= r_my;
                        o_res.gauss_exp   <= term;
                        o_res.exp_sum     <= new_sum;
                        o_res.obs_count   <= new_cnt;
                        o_res.is_last     <= r_last;
                        r_run_sum         <= r_last ? '0 : new_sum;
                        r_run_cnt         <= r_last ? '0 : new_cnt;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_score_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> r_state == S_SCAN)
        else $error("score pipeline active outside the scan");
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> r_issue <= r_n)
        else $error("scan issued past the landmark count");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_last) |=> (r_run_sum == '0 && r_run_cnt == '0))
        else $error("running sum not cleared after last observation");
    a_sum_ge_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.exp_sum >= o_res.gauss_exp)
        else $error("running sum below its own term");
`endif
endmodule
